@@ hdl/timed_wait_expiry_table_unit_macros.svh @@
// assertion macros for the timed wait expiry table
`ifndef TIMED_WAIT_EXPIRY_TABLE_UNIT_MACROS_SVH
`define TIMED_WAIT_EXPIRY_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TWEU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timed wait table check failed");
`define TWEU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timed wait table check failed");
`else
`define TWEU_ASSERT_IMP(lbl, ante, cons)
`define TWEU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/tweu_pkg.sv @@
`timescale 1ns / 1ps

package tweu_pkg;

  localparam int THREAD_W = 10;
  localparam int SEM_W    = 8;
  localparam int TICKS_W  = 16;
  localparam int OPC_W    = 2;

  localparam int DEF_TABLE_DEPTH    = 16;
  localparam int DEF_THREAD_ID_BITS = 10;

  localparam logic STATUS_EXPIRED = 1'b0;
  localparam logic STATUS_FULL    = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // verdict of the shared entry unit for the entry under scan
  typedef struct packed {
    logic               keep;
    logic               expire;
    logic               hit;
    logic [TICKS_W-1:0] ticks;
  } eval_t;

endpackage

@@ hdl/tweu_entry_ram.sv @@
`timescale 1ns / 1ps

module tweu_entry_ram import tweu_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_DEPTH,
  parameter int DW    = THREAD_W + SEM_W + TICKS_W,
  parameter int IW    = $clog2(DEF_TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [IW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/tweu_entry_eval.sv @@
`timescale 1ns / 1ps

module tweu_entry_eval import tweu_pkg::*; #(
  parameter int TW = DEF_THREAD_ID_BITS
) (
  input  logic               is_tick,
  input  logic               found,
  input  logic [TW-1:0]      key,
  input  logic [TW-1:0]      ent_thread,
  input  logic [TICKS_W-1:0] ent_ticks,
  output eval_t              ev
);

  logic due;
  logic hit;

  always_comb begin
    due = (ent_ticks <= TICKS_W'(1));
    hit = !is_tick && !found && (ent_thread == key);
    ev.hit    = hit;
    ev.expire = is_tick && due;
    ev.keep   = is_tick ? !due : !hit;
    ev.ticks  = is_tick ? (ent_ticks - TICKS_W'(1)) : ent_ticks;
  end

endmodule

@@ hdl/timed_wait_expiry_table_unit.sv @@
// an add never raises busy; a rejected add shows its result in the cycle after start
// remove and tick keep busy high through the scan and flush states (one table entry per cycle
// through the single entry ram port pair and compare/decrement unit); busy stays low if empty
// expiries come out at most one per cycle, oldest first
// results are one-cycle strobes; the receiver cannot stall
// reset: synchronous active-low rst_n empties the table and idles the sequencer
`timescale 1ns / 1ps
`include "timed_wait_expiry_table_unit_macros.svh"

module timed_wait_expiry_table_unit import tweu_pkg::*; #(
  parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH,
  parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OPC_W-1:0]    in_opcode,
  input  logic [THREAD_W-1:0] in_thread_id,
  input  logic [SEM_W-1:0]    in_sem_id,
  input  logic [TICKS_W-1:0]  in_wait_ticks,
  output logic                out_valid,
  output logic                out_status,
  output logic [THREAD_W-1:0] out_expired_thread,
  output logic [SEM_W-1:0]    out_expired_sem,
  output logic                out_last_of_run
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = (THREAD_ID_BITS < THREAD_W) ? THREAD_ID_BITS : THREAD_W;
  localparam int DW = TW + SEM_W + TICKS_W;

  state_t              state_r, state_nxt;
  opcode_t             op_r, op_nxt;
  logic [TW-1:0]       key_r, key_nxt;
  logic                found_r, found_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       proc_r, proc_nxt;
  logic [CW-1:0]       wr_r, wr_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [TW-1:0]       pend_thr_r, pend_thr_nxt;
  logic [SEM_W-1:0]    pend_sem_r, pend_sem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic [THREAD_W-1:0] out_thr_r, out_thr_nxt;
  logic [SEM_W-1:0]    out_sem_r, out_sem_nxt;
  logic                out_last_r, out_last_nxt;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [DW-1:0]       mem_rdata;

  logic [TW-1:0]       in_thr;
  logic [TW-1:0]       ent_thr;
  logic [SEM_W-1:0]    ent_sem;
  logic [TICKS_W-1:0]  ent_ticks;
  eval_t               ev;

  assign in_thr    = in_thread_id[TW-1:0];
  assign ent_thr   = mem_rdata[DW-1 -: TW];
  assign ent_sem   = mem_rdata[TICKS_W +: SEM_W];
  assign ent_ticks = mem_rdata[TICKS_W-1:0];

  tweu_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .DW    (DW),
    .IW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tweu_entry_eval #(
    .TW (TW)
  ) u_eval (
    .is_tick    (op_r == OP_TICK),
    .found      (found_r),
    .key        (key_r),
    .ent_thread (ent_thr),
    .ent_ticks  (ent_ticks),
    .ev         (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    proc_r       <= proc_nxt;
    wr_r         <= wr_nxt;
    pend_thr_r   <= pend_thr_nxt;
    pend_sem_r   <= pend_sem_nxt;
    out_status_r <= out_status_nxt;
    out_thr_r    <= out_thr_nxt;
    out_sem_r    <= out_sem_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    count_nxt      = count_r;
    proc_nxt       = proc_r;
    wr_nxt         = wr_r;
    pend_vld_nxt   = pend_vld_r;
    pend_thr_nxt   = pend_thr_r;
    pend_sem_nxt   = pend_sem_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_thr_nxt    = out_thr_r;
    out_sem_nxt    = out_sem_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_r[IW-1:0];
    mem_wdata      = {ent_thr, ent_sem, ev.ticks};
    mem_raddr      = proc_r + IW'(1);

    case (state_r)
      ST_IDLE: begin
        mem_raddr = '0;
        if (start) begin
          case (in_opcode)
            OP_ADD: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_FULL;
                out_thr_nxt    = THREAD_W'(in_thr);
                out_sem_nxt    = in_sem_id;
                out_last_nxt   = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IW-1:0];
                mem_wdata = {in_thr, in_sem_id, in_wait_ticks};
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE, OP_TICK: begin
              if (count_r != '0) begin
                op_nxt       = opcode_t'(in_opcode);
                key_nxt      = in_thr;
                found_nxt    = 1'b0;
                proc_nxt     = '0;
                wr_nxt       = '0;
                pend_vld_nxt = 1'b0;
                state_nxt    = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        found_nxt = found_r | ev.hit;
        if (ev.keep) begin
          mem_we = 1'b1;
          wr_nxt = wr_r + CW'(1);
        end
        // hold back one expiry so the final one can carry the last flag
        if (ev.expire) begin
          if (pend_vld_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EXPIRED;
            out_thr_nxt    = THREAD_W'(pend_thr_r);
            out_sem_nxt    = pend_sem_r;
            out_last_nxt   = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_thr_nxt = ent_thr;
          pend_sem_nxt = ent_sem;
        end
        if (CW'(proc_r) == count_r - CW'(1)) begin
          count_nxt = ev.keep ? (wr_r + CW'(1)) : wr_r;
          state_nxt = ST_FLUSH;
        end else begin
          proc_nxt = proc_r + IW'(1);
        end
      end

      ST_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_EXPIRED;
          out_thr_nxt    = THREAD_W'(pend_thr_r);
          out_sem_nxt    = pend_sem_r;
          out_last_nxt   = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_expired_thread = out_thr_r;
  assign out_expired_sem    = out_sem_r;
  assign out_last_of_run    = out_last_r;

  `TWEU_ASSERT_IMP(a_count_max, 1'b1, count_r <= CW'(TABLE_DEPTH))
  `TWEU_ASSERT_IMP(a_wr_behind, state_r == ST_SCAN, wr_r <= CW'(proc_r))
  `TWEU_ASSERT_NXT(a_flush_idle, state_r == ST_FLUSH, state_r == ST_IDLE)
  `TWEU_ASSERT_IMP(a_full_last, out_valid && out_status == STATUS_FULL, out_last_of_run)

endmodule
